// ===== sv/art_pkg.sv =====
package art_pkg;

    localparam int SLOTS = 32;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam int FUNC_W    = 3;
    localparam int ADDR_W    = 32;
    localparam int BYTES_W   = 32;
    localparam int ALIGN_W   = 5;
    localparam int REGION_W  = 2;
    localparam int PURPOSE_W = 3;
    localparam int LIVE_W    = 6;
    localparam int STAT_W    = 32;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [APB_AW-3:0] REG_ENABLED = '0;

    localparam logic [FUNC_W-1:0] FUNC_TRACK   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FAIL    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0]    address;
        logic [BYTES_W-1:0]   byte_count;
        logic [ALIGN_W-1:0]   align_log2;
        logic [REGION_W-1:0]  region;
        logic [PURPOSE_W-1:0] purpose;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRACK,
        ST_LOOK,
        ST_CLEAR,
        ST_DONE
    } state_t;

endpackage

// ===== sv/art_if.sv =====
interface art_req_if;
    logic                             valid;
    logic                             ready;
    logic [art_pkg::FUNC_W-1:0]       func;
    logic [art_pkg::ADDR_W-1:0]       address;
    logic [art_pkg::BYTES_W-1:0]      byte_count;
    logic [art_pkg::ALIGN_W-1:0]      align_log2;
    logic [art_pkg::REGION_W-1:0]     region;
    logic [art_pkg::PURPOSE_W-1:0]    purpose;

    modport source (output valid, func, address, byte_count, align_log2, region, purpose,
                    input ready);
    modport sink   (input valid, func, address, byte_count, align_log2, region, purpose,
                    output ready);
endinterface

interface art_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             ok;
    logic [art_pkg::BYTES_W-1:0]      found_bytes;
    logic [art_pkg::REGION_W-1:0]     found_region;
    logic [art_pkg::PURPOSE_W-1:0]    found_purpose;
    logic [art_pkg::STAT_W-1:0]       total_bytes;
    logic [art_pkg::STAT_W-1:0]       peak_bytes;
    logic [art_pkg::LIVE_W-1:0]       live_count;
    logic [art_pkg::STAT_W-1:0]       success_count;
    logic [art_pkg::STAT_W-1:0]       failure_count;

    modport source (output valid, ok, found_bytes, found_region, found_purpose, total_bytes,
                    peak_bytes, live_count, success_count, failure_count,
                    input ready);
    modport sink   (input valid, ok, found_bytes, found_region, found_purpose, total_bytes,
                    peak_bytes, live_count, success_count, failure_count,
                    output ready);
endinterface

// ===== sv/art_ram.sv =====
module art_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/allocation_record_table.sv =====
// Channel   Dir  Role                         Payload
// req       in   one operation per word       func, address, byte_count, align_log2,
//                                             region, purpose
// rsp       out  one result word per request  ok, found_*, totals and counts
// APB       in   register enabled at 0x0      pwdata[0]
//
// Note failure, refused and unknown operations go straight to the result. Track scans for the
// first free slot and fails when the table is full; release and query scan for the first
// matching slot and fail when nothing matches; clear scans every slot. The release, query
// and clear scans read the record RAM one entry per cycle through its single port.
// A result waits in the output register while rsp is stalled, which holds off the next
// request. Reset empties the table at once through the per-slot used bits.
module allocation_record_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [art_pkg::APB_AW-1:0]  paddr,
    input  logic [art_pkg::APB_DW-1:0]  pwdata,
    output logic [art_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    art_req_if.sink                     req,
    art_rsp_if.source                   rsp
);

    localparam logic [art_pkg::IDX_W-1:0] LAST_IDX = art_pkg::IDX_W'(art_pkg::SLOTS - 1);

    art_pkg::state_t                     state_reg, state_next;
    logic                                enabled_reg;
    logic [art_pkg::FUNC_W-1:0]          func_reg, func_next;
    art_pkg::slot_t                      item_reg, item_next;
    logic [art_pkg::SLOTS-1:0]           used_reg, used_next;
    logic [art_pkg::IDX_W-1:0]           idx_reg, idx_next;
    logic [art_pkg::IDX_W-1:0]           chk_idx_reg, chk_idx_next;
    logic                                chk_valid_reg, chk_valid_next;
    logic [art_pkg::STAT_W-1:0]          sum_reg, sum_next;
    logic [art_pkg::STAT_W-1:0]          max_reg, max_next;
    logic [art_pkg::CNT_W-1:0]           live_reg, live_next;
    logic [art_pkg::STAT_W-1:0]          good_reg, good_next;
    logic [art_pkg::STAT_W-1:0]          bad_reg, bad_next;
    logic                                ok_reg, ok_next;
    logic [art_pkg::BYTES_W-1:0]         fb_reg, fb_next;
    logic [art_pkg::REGION_W-1:0]        fr_reg, fr_next;
    logic [art_pkg::PURPOSE_W-1:0]       fp_reg, fp_next;
    logic                                out_valid_reg, out_valid_next;
    logic                                out_ok_reg;
    logic [art_pkg::BYTES_W-1:0]         out_fb_reg;
    logic [art_pkg::REGION_W-1:0]        out_fr_reg;
    logic [art_pkg::PURPOSE_W-1:0]       out_fp_reg;
    logic [art_pkg::STAT_W-1:0]          out_sum_reg;
    logic [art_pkg::STAT_W-1:0]          out_max_reg;
    logic [art_pkg::LIVE_W-1:0]          out_live_reg;
    logic [art_pkg::STAT_W-1:0]          out_good_reg;
    logic [art_pkg::STAT_W-1:0]          out_bad_reg;
    logic                                out_load;

    logic                                ram_we;
    art_pkg::slot_t                      ram_rdata;
    logic [art_pkg::SLOT_W-1:0]          ram_rdata_bits;

    logic                                cfg_write;
    logic [art_pkg::STAT_W-1:0]          sum_add;
    logic [art_pkg::STAT_W-1:0]          sum_floor;
    logic [art_pkg::CNT_W-1:0]           live_dec;
    logic                                hit;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[art_pkg::APB_AW-1:2] == art_pkg::REG_ENABLED)
                       ? art_pkg::APB_DW'(enabled_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
        end
        else if (cfg_write && paddr[art_pkg::APB_AW-1:2] == art_pkg::REG_ENABLED)
        begin
            enabled_reg <= pwdata[0];
        end
    end

    art_ram #(
        .WIDTH (art_pkg::SLOT_W),
        .DEPTH (art_pkg::SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (idx_reg),
        .wdata (item_reg),
        .rdata (ram_rdata_bits)
    );

    assign ram_rdata = art_pkg::slot_t'(ram_rdata_bits);

    // Shared arithmetic: one add for track, one saturating subtract for freeing a slot.
    assign sum_add   = sum_reg + item_reg.byte_count;
    assign sum_floor = (sum_reg >= ram_rdata.byte_count) ? sum_reg - ram_rdata.byte_count : '0;
    assign live_dec  = (live_reg != '0) ? live_reg - art_pkg::CNT_W'(1) : live_reg;
    assign hit       = chk_valid_reg && used_reg[chk_idx_reg]
                       && ram_rdata.address == item_reg.address;

    assign req.ready = (state_reg == art_pkg::ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        item_next      = item_reg;
        used_next      = used_reg;
        idx_next       = idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_valid_next = chk_valid_reg;
        sum_next       = sum_reg;
        max_next       = max_reg;
        live_next      = live_reg;
        good_next      = good_reg;
        bad_next       = bad_reg;
        ok_next        = ok_reg;
        fb_next        = fb_reg;
        fr_next        = fr_reg;
        fp_next        = fp_reg;
        ram_we         = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !rsp.ready;

        case (state_reg)
            art_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    func_next            = req.func;
                    item_next.address    = req.address;
                    item_next.byte_count = req.byte_count;
                    item_next.align_log2 = req.align_log2;
                    item_next.region     = req.region;
                    item_next.purpose    = req.purpose;
                    idx_next             = '0;
                    chk_valid_next       = 1'b0;
                    ok_next              = 1'b0;
                    fb_next              = '0;
                    fr_next              = '0;
                    fp_next              = '0;
                    state_next           = art_pkg::ST_DONE;
                    case (req.func) inside
                        art_pkg::FUNC_TRACK:
                        begin
                            if (req.address != '0)
                            begin
                                state_next = art_pkg::ST_TRACK;
                            end
                        end
                        art_pkg::FUNC_RELEASE, art_pkg::FUNC_QUERY:
                        begin
                            if (enabled_reg && req.address != '0)
                            begin
                                state_next = art_pkg::ST_LOOK;
                            end
                        end
                        art_pkg::FUNC_FAIL:
                        begin
                            bad_next = bad_reg + art_pkg::STAT_W'(1);
                            ok_next  = 1'b1;
                        end
                        art_pkg::FUNC_CLEAR:
                        begin
                            if (enabled_reg)
                            begin
                                state_next = art_pkg::ST_CLEAR;
                            end
                        end
                        default:
                        begin
                            state_next = art_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            art_pkg::ST_TRACK:
            begin
                if (!used_reg[idx_reg])
                begin
                    ram_we             = 1'b1;
                    used_next[idx_reg] = 1'b1;
                    sum_next           = sum_add;
                    if (sum_add > max_reg)
                    begin
                        max_next = sum_add;
                    end
                    live_next  = live_reg + art_pkg::CNT_W'(1);
                    good_next  = good_reg + art_pkg::STAT_W'(1);
                    ok_next    = 1'b1;
                    state_next = art_pkg::ST_DONE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    bad_next   = bad_reg + art_pkg::STAT_W'(1);
                    state_next = art_pkg::ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + art_pkg::IDX_W'(1);
                end
            end

            // Read one slot per cycle; a slot is compared in the cycle after its address.
            art_pkg::ST_LOOK:
            begin
                chk_valid_next = 1'b1;
                chk_idx_next   = idx_reg;
                if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + art_pkg::IDX_W'(1);
                end
                if (hit)
                begin
                    ok_next    = 1'b1;
                    fb_next    = ram_rdata.byte_count;
                    fr_next    = ram_rdata.region;
                    fp_next    = ram_rdata.purpose;
                    state_next = art_pkg::ST_DONE;
                    if (func_reg == art_pkg::FUNC_RELEASE)
                    begin
                        used_next[chk_idx_reg] = 1'b0;
                        sum_next               = sum_floor;
                        live_next              = live_dec;
                    end
                end
                else if (chk_valid_reg && chk_idx_reg == LAST_IDX)
                begin
                    state_next = art_pkg::ST_DONE;
                end
            end

            art_pkg::ST_CLEAR:
            begin
                chk_valid_next = 1'b1;
                chk_idx_next   = idx_reg;
                if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + art_pkg::IDX_W'(1);
                end
                if (chk_valid_reg && used_reg[chk_idx_reg])
                begin
                    used_next[chk_idx_reg] = 1'b0;
                    sum_next               = sum_floor;
                    live_next              = live_dec;
                end
                if (chk_valid_reg && chk_idx_reg == LAST_IDX)
                begin
                    ok_next    = 1'b1;
                    state_next = art_pkg::ST_DONE;
                end
            end

            art_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = art_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = art_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= art_pkg::ST_IDLE;
            used_reg      <= '0;
            idx_reg       <= '0;
            chk_idx_reg   <= '0;
            chk_valid_reg <= 1'b0;
            sum_reg       <= '0;
            max_reg       <= '0;
            live_reg      <= '0;
            good_reg      <= '0;
            bad_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            idx_reg       <= idx_next;
            chk_idx_reg   <= chk_idx_next;
            chk_valid_reg <= chk_valid_next;
            sum_reg       <= sum_next;
            max_reg       <= max_next;
            live_reg      <= live_next;
            good_reg      <= good_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        item_reg <= item_next;
        ok_reg   <= ok_next;
        fb_reg   <= fb_next;
        fr_reg   <= fr_next;
        fp_reg   <= fp_next;
        if (out_load)
        begin
            out_ok_reg   <= ok_reg;
            out_fb_reg   <= fb_reg;
            out_fr_reg   <= fr_reg;
            out_fp_reg   <= fp_reg;
            out_sum_reg  <= sum_reg;
            out_max_reg  <= max_reg;
            out_live_reg <= art_pkg::LIVE_W'(live_reg);
            out_good_reg <= good_reg;
            out_bad_reg  <= bad_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.ok            = out_ok_reg;
    assign rsp.found_bytes   = out_fb_reg;
    assign rsp.found_region  = out_fr_reg;
    assign rsp.found_purpose = out_fp_reg;
    assign rsp.total_bytes   = out_sum_reg;
    assign rsp.peak_bytes    = out_max_reg;
    assign rsp.live_count    = out_live_reg;
    assign rsp.success_count = out_good_reg;
    assign rsp.failure_count = out_bad_reg;

endmodule

// ===== sv/art_checker.sv =====
module art_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic                              rsp_ok,
    input logic [art_pkg::BYTES_W-1:0]       rsp_found_bytes,
    input logic [art_pkg::REGION_W-1:0]      rsp_found_region,
    input logic [art_pkg::PURPOSE_W-1:0]     rsp_found_purpose,
    input logic [art_pkg::STAT_W-1:0]        rsp_total_bytes,
    input logic [art_pkg::STAT_W-1:0]        rsp_peak_bytes,
    input logic [art_pkg::LIVE_W-1:0]        rsp_live_count
);

    // A stalled result word must hold its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok)
            && $stable(rsp_total_bytes) && $stable(rsp_found_bytes))
        else $error("result word changed while stalled");

    // The block works on one request at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in progress");

    // The peak can never fall below the live total, even across a wrap.
    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_peak_bytes >= rsp_total_bytes)
        else $error("peak bytes below total bytes");

    // A failed operation reports no record.
    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> rsp_found_bytes == '0 && rsp_found_region == '0
            && rsp_found_purpose == '0)
        else $error("record fields set on a failed operation");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (art_pkg::SLOTS > 63) || rsp_live_count <= art_pkg::LIVE_W'(art_pkg::SLOTS))
        else $error("live count above table size");

endmodule

bind allocation_record_table art_checker u_art_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_ok            (rsp.ok),
    .rsp_found_bytes   (rsp.found_bytes),
    .rsp_found_region  (rsp.found_region),
    .rsp_found_purpose (rsp.found_purpose),
    .rsp_total_bytes   (rsp.total_bytes),
    .rsp_peak_bytes    (rsp.peak_bytes),
    .rsp_live_count    (rsp.live_count)
);

// ===== tb/allocation_record_table_test.sv =====
`timescale 1ns / 100ps

module allocation_record_table_test;

    localparam int STALL_LIMIT = 4000;
    localparam int POOL = 24;
    localparam logic [art_pkg::FUNC_W-1:0] FUNC_UNKNOWN_LO = art_pkg::FUNC_CLEAR + 1'b1;
    localparam logic [art_pkg::FUNC_W-1:0] FUNC_LAST = '1;

    typedef struct packed {
        logic [art_pkg::FUNC_W-1:0]    func;
        logic [art_pkg::ADDR_W-1:0]    address;
        logic [art_pkg::BYTES_W-1:0]   byte_count;
        logic [art_pkg::ALIGN_W-1:0]   align_log2;
        logic [art_pkg::REGION_W-1:0]  region;
        logic [art_pkg::PURPOSE_W-1:0] purpose;
    } table_op_t;

    typedef struct packed {
        logic                          ok;
        logic [art_pkg::BYTES_W-1:0]   found_bytes;
        logic [art_pkg::REGION_W-1:0]  found_region;
        logic [art_pkg::PURPOSE_W-1:0] found_purpose;
        logic [art_pkg::STAT_W-1:0]    total_bytes;
        logic [art_pkg::STAT_W-1:0]    peak_bytes;
        logic [art_pkg::LIVE_W-1:0]    live_count;
        logic [art_pkg::STAT_W-1:0]    success_count;
        logic [art_pkg::STAT_W-1:0]    failure_count;
    } table_status_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [art_pkg::APB_AW-1:0] paddr;
    logic [art_pkg::APB_DW-1:0] pwdata;
    logic [art_pkg::APB_DW-1:0] prdata;
    logic pready;

    art_req_if req_if ();
    art_rsp_if rsp_if ();

    allocation_record_table dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_if),
        .rsp     (rsp_if)
    );

    // Shadow copy of the record table and its running totals.
    bit                            mgr_enabled = 1'b0;
    bit                            rec_used    [art_pkg::SLOTS];
    logic [art_pkg::ADDR_W-1:0]    rec_addr    [art_pkg::SLOTS];
    logic [art_pkg::BYTES_W-1:0]   rec_bytes   [art_pkg::SLOTS];
    logic [art_pkg::REGION_W-1:0]  rec_region  [art_pkg::SLOTS];
    logic [art_pkg::PURPOSE_W-1:0] rec_purpose [art_pkg::SLOTS];
    logic [art_pkg::STAT_W-1:0]    live_bytes   = '0;
    logic [art_pkg::STAT_W-1:0]    peak_seen    = '0;
    int                            live_recs    = 0;
    logic [art_pkg::STAT_W-1:0]    track_ok_cnt = '0;
    logic [art_pkg::STAT_W-1:0]    fail_cnt     = '0;

    table_status_t status_due[$];
    int            status_errors = 0;
    bit            steady_flow   = 1'b0;
    logic [art_pkg::ADDR_W-1:0] addr_pool [POOL];

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic void free_record(int s);
        if (live_bytes >= rec_bytes[s])
            live_bytes = live_bytes - rec_bytes[s];
        else
            live_bytes = '0;
        if (live_recs > 0)
            live_recs--;
        rec_used[s] = 1'b0;
    endfunction

    function automatic table_status_t predict_status(table_op_t op);
        table_status_t st;
        int hit;
        st = '0;
        hit = -1;
        case (op.func)
            art_pkg::FUNC_TRACK:
                if (op.address != '0)
                begin
                    for (int s = 0; s < art_pkg::SLOTS && hit < 0; s++)
                        if (!rec_used[s])
                            hit = s;
                    if (hit >= 0)
                    begin
                        rec_used[hit]    = 1'b1;
                        rec_addr[hit]    = op.address;
                        rec_bytes[hit]   = op.byte_count;
                        rec_region[hit]  = op.region;
                        rec_purpose[hit] = op.purpose;
                        live_bytes   = live_bytes + op.byte_count;
                        live_recs++;
                        track_ok_cnt = track_ok_cnt + 1'b1;
                        if (live_bytes > peak_seen)
                            peak_seen = live_bytes;
                        st.ok = 1'b1;
                    end
                    else
                        fail_cnt = fail_cnt + 1'b1;
                end
            art_pkg::FUNC_RELEASE, art_pkg::FUNC_QUERY:
                if (mgr_enabled && op.address != '0)
                begin
                    for (int s = 0; s < art_pkg::SLOTS && hit < 0; s++)
                        if (rec_used[s] && rec_addr[s] == op.address)
                            hit = s;
                    if (hit >= 0)
                    begin
                        st.ok            = 1'b1;
                        st.found_bytes   = rec_bytes[hit];
                        st.found_region  = rec_region[hit];
                        st.found_purpose = rec_purpose[hit];
                        if (op.func == art_pkg::FUNC_RELEASE)
                            free_record(hit);
                    end
                end
            art_pkg::FUNC_FAIL:
            begin
                fail_cnt = fail_cnt + 1'b1;
                st.ok = 1'b1;
            end
            art_pkg::FUNC_CLEAR:
                if (mgr_enabled)
                begin
                    for (int s = 0; s < art_pkg::SLOTS; s++)
                        if (rec_used[s])
                            free_record(s);
                    st.ok = 1'b1;
                end
            default:
                ;
        endcase
        st.total_bytes   = live_bytes;
        st.peak_bytes    = peak_seen;
        st.live_count    = art_pkg::LIVE_W'(live_recs);
        st.success_count = track_ok_cnt;
        st.failure_count = fail_cnt;
        return st;
    endfunction

    function automatic string show_status(table_status_t st);
        return $sformatf({"ok=%0d bytes=%h region=%0d purpose=%0d ",
                          "total=%h peak=%h live=%0d good=%0d bad=%0d"},
                         st.ok, st.found_bytes, st.found_region, st.found_purpose,
                         st.total_bytes, st.peak_bytes, st.live_count,
                         st.success_count, st.failure_count);
    endfunction

    // Mostly short gaps, now and then a long one; none at all in steady phases.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic table_op_t make_op(logic [art_pkg::FUNC_W-1:0] func,
                                          logic [art_pkg::ADDR_W-1:0] address,
                                          logic [art_pkg::BYTES_W-1:0] byte_count,
                                          logic [art_pkg::ALIGN_W-1:0] align_log2,
                                          logic [art_pkg::REGION_W-1:0] region,
                                          logic [art_pkg::PURPOSE_W-1:0] purpose);
        table_op_t op;
        op.func       = func;
        op.address    = address;
        op.byte_count = byte_count;
        op.align_log2 = align_log2;
        op.region     = region;
        op.purpose    = purpose;
        return op;
    endfunction

    // Addresses come mostly from a small pool, so that releases and queries hit live records.
    function automatic table_op_t rand_op(int track_pct);
        table_op_t op;
        int r;
        r = $urandom_range(0, 99);
        if (r < track_pct)
            op.func = art_pkg::FUNC_TRACK;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                op.func = art_pkg::FUNC_RELEASE;
            else if (r < 83)
                op.func = art_pkg::FUNC_QUERY;
            else if (r < 92)
                op.func = art_pkg::FUNC_FAIL;
            else if (r < 97)
                op.func = art_pkg::FUNC_W'($urandom_range(FUNC_UNKNOWN_LO, FUNC_LAST));
            else
                op.func = art_pkg::FUNC_CLEAR;
        end
        r = $urandom_range(0, 19);
        if (r == 0)
            op.address = '0;
        else if (r == 1)
            op.address = $urandom();
        else
            op.address = addr_pool[$urandom_range(0, POOL - 1)];
        r = $urandom_range(0, 7);
        if (r == 0)
            op.byte_count = $urandom();
        else if (r == 1)
            op.byte_count = $urandom_range(0, 1) ? '1 : '0;
        else
            op.byte_count = $urandom_range(1, 65536);
        op.align_log2 = art_pkg::ALIGN_W'($urandom());
        op.region     = art_pkg::REGION_W'($urandom());
        op.purpose    = art_pkg::PURPOSE_W'($urandom());
        return op;
    endfunction

    // Valid stays high from one word to the next unless a gap is drawn.
    task automatic issue_op(input table_op_t op);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.func       <= op.func;
        req_if.address    <= op.address;
        req_if.byte_count <= op.byte_count;
        req_if.align_log2 <= op.align_log2;
        req_if.region     <= op.region;
        req_if.purpose    <= op.purpose;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        status_due.push_back(predict_status(op));
    endtask

    task automatic quiesce();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (status_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_enabled(input bit value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {art_pkg::REG_ENABLED, 2'b00};
        pwdata  <= art_pkg::APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mgr_enabled = value;
        @(posedge clk);
    endtask

    task automatic test_disabled_manager();
        set_enabled(1'b0);
        issue_op(make_op(art_pkg::FUNC_QUERY, 32'h1234_5678, '0, '0, '0, '0));
        issue_op(make_op(art_pkg::FUNC_RELEASE, 32'h1234_5678, '0, '0, '0, '0));
        issue_op(make_op(art_pkg::FUNC_CLEAR, '0, '0, '0, '0, '0));
        // A null address is refused whatever the enable.
        issue_op(make_op(art_pkg::FUNC_TRACK, '0, 32'h55, 5'd3, 2'd1, 3'd1));
        issue_op(make_op(art_pkg::FUNC_TRACK, 32'h1234_5678, 32'h100, 5'd2, 2'd1, 3'd0));
        issue_op(make_op(art_pkg::FUNC_QUERY, 32'h1234_5678, '0, '0, '0, '0));
        issue_op(make_op(art_pkg::FUNC_FAIL, '0, '0, '0, '0, '0));
        issue_op(make_op(FUNC_UNKNOWN_LO, 32'h1234_5678, '1, '1, '1, '1));
        issue_op(make_op(FUNC_LAST, 32'h1234_5678, '1, '1, '1, '1));
        quiesce();
    endtask

    task automatic test_enabled_records();
        set_enabled(1'b1);
        issue_op(make_op(art_pkg::FUNC_QUERY, 32'h1234_5678, '0, '0, '0, '0));
        issue_op(make_op(art_pkg::FUNC_QUERY, '0, '0, '0, '0, '0));
        issue_op(make_op(art_pkg::FUNC_RELEASE, '0, '0, '0, '0, '0));
        issue_op(make_op(art_pkg::FUNC_TRACK, 32'h8000_0000, 32'h7FFF_FF00, 5'd12, 2'd2,
                         3'd6));
        // The running total wraps here, and the release of this record later hits the floor.
        issue_op(make_op(art_pkg::FUNC_TRACK, '1, '1, 5'd31, 2'd3, 3'd7));
        issue_op(make_op(art_pkg::FUNC_TRACK, 32'h1234_5678, '0, '0, '0, 3'd5));
        issue_op(make_op(art_pkg::FUNC_QUERY, 32'h1234_5678, '0, '0, '0, '0));
        issue_op(make_op(art_pkg::FUNC_RELEASE, '1, '0, '0, '0, '0));
        issue_op(make_op(art_pkg::FUNC_RELEASE, 32'h1234_5678, '0, '0, '0, '0));
        issue_op(make_op(art_pkg::FUNC_QUERY, 32'h1234_5678, '0, '0, '0, '0));
        issue_op(make_op(art_pkg::FUNC_RELEASE, 32'h1234_5678, '0, '0, '0, '0));
        issue_op(make_op(art_pkg::FUNC_RELEASE, 32'h1234_5678, '0, '0, '0, '0));
        issue_op(make_op(art_pkg::FUNC_QUERY, 32'h0BAD_F00D, '0, '0, '0, '0));
        issue_op(make_op(art_pkg::FUNC_TRACK, 32'h0000_0001, 32'h10, 5'd4, 2'd1, 3'd2));
        issue_op(make_op(art_pkg::FUNC_CLEAR, '0, '0, '0, '0, '0));
        issue_op(make_op(art_pkg::FUNC_QUERY, 32'h0000_0001, '0, '0, '0, '0));
        quiesce();
    endtask

    task automatic test_table_full();
        set_enabled(1'b1);
        for (int i = 0; i < art_pkg::SLOTS + 3; i++)
            issue_op(rand_op(100));
        issue_op(make_op(art_pkg::FUNC_CLEAR, '0, '0, '0, '0, '0));
        quiesce();
    endtask

    task automatic test_random_traffic(input int count, input bit enable, input bit steady,
                                       input int track_pct);
        set_enabled(enable);
        steady_flow = steady;
        for (int i = 0; i < count; i++)
            issue_op(rand_op(track_pct));
        quiesce();
        steady_flow = 1'b0;
    endtask

    initial
    begin : rsp_drain
        int hold;
        hold = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold == 0 && !steady_flow && $urandom_range(0, 3) == 0)
                hold = pick_gap();
            if (hold > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold--;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : status_check
        table_status_t seen;
        table_status_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            seen.ok            = rsp_if.ok;
            seen.found_bytes   = rsp_if.found_bytes;
            seen.found_region  = rsp_if.found_region;
            seen.found_purpose = rsp_if.found_purpose;
            seen.total_bytes   = rsp_if.total_bytes;
            seen.peak_bytes    = rsp_if.peak_bytes;
            seen.live_count    = rsp_if.live_count;
            seen.success_count = rsp_if.success_count;
            seen.failure_count = rsp_if.failure_count;
            if (status_due.size() == 0)
            begin
                status_errors++;
                if (status_errors <= 10)
                    $display("%0t: result word with none expected: %s", $realtime,
                             show_status(seen));
            end
            else
            begin
                want = status_due.pop_front();
                if (seen.ok !== want.ok || seen.found_bytes !== want.found_bytes ||
                    seen.found_region !== want.found_region ||
                    seen.found_purpose !== want.found_purpose ||
                    seen.total_bytes !== want.total_bytes ||
                    seen.peak_bytes !== want.peak_bytes ||
                    seen.live_count !== want.live_count ||
                    seen.success_count !== want.success_count ||
                    seen.failure_count !== want.failure_count)
                begin
                    status_errors++;
                    if (status_errors <= 10)
                    begin
                        $display("%0t: expected %s", $realtime, show_status(want));
                        $display("%0t: actual   %s", $realtime, show_status(seen));
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        req_if.valid       <= 1'b0;
        req_if.func        <= '0;
        req_if.address     <= '0;
        req_if.byte_count  <= '0;
        req_if.align_log2  <= '0;
        req_if.region      <= '0;
        req_if.purpose     <= '0;
        for (int s = 0; s < art_pkg::SLOTS; s++)
            rec_used[s] = 1'b0;
        for (int i = 0; i < POOL; i++)
        begin
            addr_pool[i] = $urandom();
            while (addr_pool[i] == '0)
                addr_pool[i] = $urandom();
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled_manager();
        test_enabled_records();
        test_table_full();
        test_random_traffic(300, 1'b1, 1'b0, 50);
        test_random_traffic(250, 1'b1, 1'b1, 45);
        test_random_traffic(150, 1'b0, 1'b0, 65);
        test_random_traffic(350, 1'b1, 1'b0, 40);
        test_random_traffic(300, 1'b1, 1'b0, 55);

        repeat (art_pkg::SLOTS + 8) @(posedge clk);
        if (status_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
